@@ rtl/tcqsa_pkg.sv @@
// Shared types, constants and helper functions of the queue space allocator.
package tcqsa_pkg;

    // Default values for the top-level parameters
    localparam int DEF_GLOBAL_HEADER_BYTES  = 8;
    localparam int DEF_MESSAGE_HEADER_BYTES = 8;
    localparam int DEF_LINK_BYTES           = 8;
    localparam int DEF_INITIAL_BYTES        = 4096;
    localparam int DEF_MAX_BYTES            = 16777216;
    localparam int DEF_WORD_BITS            = 26;

    // Request modes
    localparam logic [1:0] MODE_START  = 2'd0;
    localparam logic [1:0] MODE_RESIZE = 2'd1;
    localparam logic [1:0] MODE_COMMIT = 2'd2;

    // Error codes
    localparam logic [1:0] ERR_OK    = 2'd0;
    localparam logic [1:0] ERR_SEQ   = 2'd1;
    localparam logic [1:0] ERR_LIMIT = 2'd2;

    // Chunk layouts; PEND_NONE marks no pending message
    localparam logic [2:0] PEND_NONE = 3'd0;
    localparam logic [2:0] L_ONE     = 3'd1;
    localparam logic [2:0] L_TWO     = 3'd2;
    localparam logic [2:0] L_THREE   = 3'd3;
    localparam logic [2:0] L_WRAP    = 3'd4;

    // Layout that remains after the oldest chunk is retired
    localparam logic [2:0] RETIRE_MAP [5] = '{3'd0, 3'd0, L_ONE, L_WRAP, L_ONE};

    typedef struct packed {
        logic [1:0]  mode;
        logic [23:0] length;
        logic [24:0] reader_tail;
    } req_t;

    typedef struct packed {
        logic [24:0] place_offset;
        logic [24:0] buffer_bytes;
        logic        grew;
        logic        moved;
        logic [24:0] move_source;
        logic [2:0]  alloc_mode;
        logic [1:0]  error;
    } rsp_t;

    typedef struct packed {
        logic lt;
        logic gt;
    } alu_flags_t;

    function automatic logic [2:0] retire_next(input logic [2:0] st);
        logic [2:0] idx;
        logic [2:0] v;
        idx = (st[1:0] != 2'b00) ? st : 3'd0;
        if (idx > 3'd4)
            v = L_ONE;
        else
            v = RETIRE_MAP[idx];
        if (v == 3'd0)
            v = L_ONE;
        return v;
    endfunction

    // Index of the chunk that receives new messages in a given layout
    function automatic logic [1:0] head_index(input logic [2:0] st);
        logic [1:0] idx;
        unique case (st)
            L_TWO, L_WRAP: idx = 2'd1;
            L_THREE:       idx = 2'd2;
            default:       idx = 2'd0;
        endcase
        return idx;
    endfunction

endpackage

@@ rtl/tcqsa_alu.sv @@
// Shared adder and magnitude comparator used by the allocation sequencer.
module tcqsa_alu
    import tcqsa_pkg::*;
#(
    parameter int W = DEF_WORD_BITS
)
(
    input  logic [W-1:0] a,
    input  logic [W-1:0] b,
    input  logic [W-1:0] c,
    output logic [W-1:0] sum,
    output alu_flags_t   flags
);

    always_comb
    begin
        sum      = a + b;
        flags.lt = (sum < c);
        flags.gt = (sum > c);
    end

endmodule

@@ rtl/three_chunk_queue_space_allocator.sv @@
// Writer-side space allocator: sequencer, layout state and result register.
// Start: retirement check (S_RLO/S_RHI, for up to two chunks), tail advance (S_TLO/S_THI),
//   span (S_RND/S_SPAN), placement (S_FIT/S_NEED), then S_DBL once per buffer doubling; a
//   growing resize first passes S_SHRINK. Commit runs S_RND, S_SPAN and S_CSUM.
// One request at a time; the sequencer's additions go through the single shared adder/comparator.
// Reset (rst_n low, asynchronous) restores one chunk, nothing pending, INITIAL_BYTES.
module three_chunk_queue_space_allocator
    import tcqsa_pkg::*;
#(
    parameter int GLOBAL_HEADER_BYTES  = DEF_GLOBAL_HEADER_BYTES,
    parameter int MESSAGE_HEADER_BYTES = DEF_MESSAGE_HEADER_BYTES,
    parameter int LINK_BYTES           = DEF_LINK_BYTES,
    parameter int INITIAL_BYTES        = DEF_INITIAL_BYTES,
    parameter int MAX_BYTES            = DEF_MAX_BYTES
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_ready,
    output rsp_t rsp
);

    localparam int W = ($clog2(MAX_BYTES) + 2 > 26) ? $clog2(MAX_BYTES) + 2 : 26;

    localparam logic [W-1:0] GHB_W      = W'(GLOBAL_HEADER_BYTES);
    localparam logic [W-1:0] LINK_W     = W'(LINK_BYTES);
    localparam logic [W-1:0] HDR_LINK_W = W'(MESSAGE_HEADER_BYTES + LINK_BYTES);
    localparam logic [W-1:0] INIT_W     = W'(INITIAL_BYTES);
    localparam logic [W-1:0] MAX_W      = W'(MAX_BYTES);
    localparam logic [W-1:0] ROUND_W    = W'(7);

    typedef enum logic [12:0] {
        S_IDLE   = 13'b0000000000001,
        S_SHRINK = 13'b0000000000010,
        S_RLO    = 13'b0000000000100,
        S_RHI    = 13'b0000000001000,
        S_TLO    = 13'b0000000010000,
        S_THI    = 13'b0000000100000,
        S_RND    = 13'b0000001000000,
        S_SPAN   = 13'b0000010000000,
        S_FIT    = 13'b0000100000000,
        S_NEED   = 13'b0001000000000,
        S_DBL    = 13'b0010000000000,
        S_CSUM   = 13'b0100000000000,
        S_DONE   = 13'b1000000000000
    } state_t;

    // Control and committed layout state
    state_t       state_reg, state_next;
    logic         retry_reg, retry_next;
    logic         rsp_valid_reg, rsp_valid_next;
    logic [2:0]   layout_reg, layout_next;
    logic [W-1:0] ct_reg [3];
    logic [W-1:0] ct_next [3];
    logic [W-1:0] ch_reg [3];
    logic [W-1:0] ch_next [3];
    logic [2:0]   pend_st_reg, pend_st_next;
    logic [W-1:0] pend_off_reg, pend_off_next;
    logic [23:0]  pend_len_reg, pend_len_next;
    logic [W-1:0] size_reg, size_next;

    // Working registers of one transaction
    logic [1:0]   mode_reg, mode_next;
    logic [23:0]  len_reg, len_next;
    logic [W-1:0] tail_reg, tail_next;
    logic         lo_reg, lo_next;
    logic [W-1:0] span_reg, span_next;
    logic [W-1:0] off_reg, off_next;
    logic [2:0]   nst_reg, nst_next;
    logic [W-1:0] need_reg, need_next;
    logic [W-1:0] psize_reg, psize_next;
    logic [2:0]   p_st_reg, p_st_next;
    logic [W-1:0] p_ct_reg [2];
    logic [W-1:0] p_ct_next [2];
    logic [W-1:0] p_ch_reg [2];
    logic [W-1:0] p_ch_next [2];
    rsp_t         res_reg, res_next;
    rsp_t         rsp_reg, rsp_next;

    // Shared unit
    logic [W-1:0] alu_a, alu_b, alu_c, alu_sum;
    alu_flags_t   alu_fl;

    logic [1:0]   head_ly, head_pl;
    logic [W-1:0] p_head;
    logic         new_chunk;
    logic         seq_ok;
    logic         size_ok;
    logic         mv;
    logic [2:0]   lay_c;

    tcqsa_alu #(
        .W (W)
    ) u_alu (
        .a     (alu_a),
        .b     (alu_b),
        .c     (alu_c),
        .sum   (alu_sum),
        .flags (alu_fl)
    );

    assign head_ly   = head_index(layout_reg);
    assign head_pl   = head_index(p_st_reg);
    assign new_chunk = (pend_st_reg != layout_reg) &&
                       (layout_reg == L_ONE || layout_reg == L_TWO);
    assign seq_ok    = (req.mode == MODE_START  && pend_st_reg == PEND_NONE) ||
                       (req.mode == MODE_RESIZE && pend_st_reg != PEND_NONE) ||
                       (req.mode == MODE_COMMIT && pend_st_reg != PEND_NONE);
    assign size_ok   = (psize_reg <= MAX_W);
    assign mv        = (mode_reg == MODE_RESIZE) && (off_reg != pend_off_reg);
    assign lay_c     = (pend_st_reg >= L_ONE && pend_st_reg <= L_WRAP) ? pend_st_reg
                                                                        : layout_reg;

    always_comb
    begin
        case (head_pl)
            2'd0:    p_head = p_ch_reg[0];
            2'd1:    p_head = p_ch_reg[1];
            default: p_head = ch_reg[2];
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        retry_next     = retry_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        rsp_next       = rsp_reg;
        layout_next    = layout_reg;
        for (int i = 0; i < 3; i++)
        begin
            ct_next[i] = ct_reg[i];
            ch_next[i] = ch_reg[i];
        end
        pend_st_next  = pend_st_reg;
        pend_off_next = pend_off_reg;
        pend_len_next = pend_len_reg;
        size_next     = size_reg;
        mode_next     = mode_reg;
        len_next      = len_reg;
        tail_next     = tail_reg;
        lo_next       = lo_reg;
        span_next     = span_reg;
        off_next      = off_reg;
        nst_next      = nst_reg;
        need_next     = need_reg;
        psize_next    = psize_reg;
        p_st_next     = p_st_reg;
        for (int i = 0; i < 2; i++)
        begin
            p_ct_next[i] = p_ct_reg[i];
            p_ch_next[i] = p_ch_reg[i];
        end
        res_next = res_reg;
        alu_a    = tail_reg;
        alu_b    = '0;
        alu_c    = p_ct_reg[0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    mode_next  = req.mode;
                    len_next   = req.length;
                    tail_next  = W'(req.reader_tail);
                    retry_next = 1'b0;
                    p_st_next  = layout_reg;
                    for (int i = 0; i < 2; i++)
                    begin
                        p_ct_next[i] = ct_reg[i];
                        p_ch_next[i] = ch_reg[i];
                    end
                    if (!seq_ok)
                    begin
                        res_next              = '0;
                        res_next.buffer_bytes = size_reg[24:0];
                        res_next.alloc_mode   = layout_reg;
                        res_next.error        = ERR_SEQ;
                        state_next            = S_DONE;
                    end
                    else if (req.mode == MODE_START)
                        state_next = S_RLO;
                    else if (req.mode == MODE_RESIZE)
                        state_next = S_SHRINK;
                    else
                        state_next = S_RND;
                end
            end
            S_SHRINK:
            begin
                alu_a = W'(len_reg);
                alu_c = W'(pend_len_reg);
                if (!alu_fl.gt)
                begin
                    pend_len_next         = len_reg;
                    res_next              = '0;
                    res_next.place_offset = pend_off_reg[24:0];
                    res_next.buffer_bytes = size_reg[24:0];
                    res_next.alloc_mode   = layout_reg;
                    res_next.error        = ERR_OK;
                    state_next            = S_DONE;
                end
                else
                    state_next = S_RLO;
            end
            S_RLO:
            begin
                alu_c = p_ct_reg[0];
                if (p_st_reg == L_ONE)
                    state_next = S_TLO;
                else
                begin
                    lo_next    = alu_fl.lt;
                    state_next = S_RHI;
                end
            end
            S_RHI:
            begin
                alu_c = p_ch_reg[0];
                if (!lo_reg && alu_fl.lt)
                    state_next = S_TLO;
                else
                begin
                    // drop the oldest chunk
                    p_ct_next[0] = p_ct_reg[1];
                    p_ch_next[0] = p_ch_reg[1];
                    p_ct_next[1] = ct_reg[2];
                    p_ch_next[1] = ch_reg[2];
                    p_st_next    = retire_next(p_st_reg);
                    if (retry_reg)
                        state_next = S_TLO;
                    else
                    begin
                        retry_next = 1'b1;
                        state_next = S_RLO;
                    end
                end
            end
            S_TLO:
            begin
                alu_c      = p_ct_reg[0];
                lo_next    = alu_fl.lt;
                state_next = S_THI;
            end
            S_THI:
            begin
                // advance the oldest tail only if a full link still fits before its head
                alu_b = LINK_W;
                alu_c = p_ch_reg[0];
                if (!lo_reg && !alu_fl.gt)
                    p_ct_next[0] = tail_reg;
                state_next = S_RND;
            end
            S_RND:
            begin
                alu_a      = (mode_reg == MODE_COMMIT) ? W'(pend_len_reg) : W'(len_reg);
                alu_b      = ROUND_W;
                span_next  = {alu_sum[W-1:3], 3'b000};
                state_next = S_SPAN;
            end
            S_SPAN:
            begin
                alu_a      = span_reg;
                alu_b      = HDR_LINK_W;
                span_next  = alu_sum;
                state_next = (mode_reg == MODE_COMMIT) ? S_CSUM : S_FIT;
            end
            S_FIT:
            begin
                alu_a    = span_reg;
                alu_b    = (p_st_reg == L_TWO) ? p_ch_reg[1] : GHB_W;
                alu_c    = p_ct_reg[0];
                off_next = p_head;
                nst_next = p_st_reg;
                if (p_st_reg == L_ONE && !alu_fl.gt)
                begin
                    off_next = GHB_W;
                    nst_next = L_TWO;
                end
                else if (p_st_reg == L_TWO && alu_fl.gt)
                begin
                    off_next = p_ch_reg[0];
                    nst_next = L_THREE;
                end
                state_next = S_NEED;
            end
            S_NEED:
            begin
                alu_a      = off_reg;
                alu_b      = span_reg;
                need_next  = alu_sum;
                psize_next = size_reg;
                state_next = S_DBL;
            end
            S_DBL:
            begin
                alu_a = psize_reg;
                alu_c = need_reg;
                if (alu_fl.lt && size_ok)
                    psize_next = {psize_reg[W-2:0], 1'b0};
                else
                begin
                    res_next              = '0;
                    res_next.buffer_bytes = size_reg[24:0];
                    res_next.alloc_mode   = layout_reg;
                    res_next.error        = ERR_LIMIT;
                    if (size_ok)
                    begin
                        layout_next = p_st_reg;
                        for (int i = 0; i < 2; i++)
                        begin
                            ct_next[i] = p_ct_reg[i];
                            ch_next[i] = p_ch_reg[i];
                        end
                        size_next             = psize_reg;
                        pend_st_next          = nst_reg;
                        pend_off_next         = off_reg;
                        pend_len_next         = len_reg;
                        res_next.place_offset = off_reg[24:0];
                        res_next.buffer_bytes = psize_reg[24:0];
                        res_next.grew         = (psize_reg != size_reg);
                        res_next.moved        = mv;
                        res_next.move_source  = mv ? pend_off_reg[24:0] : 25'd0;
                        res_next.alloc_mode   = p_st_reg;
                        res_next.error        = ERR_OK;
                    end
                    state_next = S_DONE;
                end
            end
            S_CSUM:
            begin
                alu_a = new_chunk ? pend_off_reg : ch_reg[head_ly];
                alu_b = span_reg;
                if (new_chunk)
                begin
                    ct_next[layout_reg[1:0]] = pend_off_reg;
                    ch_next[layout_reg[1:0]] = alu_sum;
                end
                else
                    ch_next[head_ly] = alu_sum;
                layout_next           = lay_c;
                res_next              = '0;
                res_next.place_offset = pend_off_reg[24:0];
                res_next.buffer_bytes = size_reg[24:0];
                res_next.alloc_mode   = lay_c;
                res_next.error        = ERR_OK;
                pend_st_next          = PEND_NONE;
                pend_off_next         = '0;
                pend_len_next         = '0;
                state_next            = S_DONE;
            end
            S_DONE:
            begin
                // hold until the output register is free
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_next       = res_reg;
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            retry_reg     <= 1'b0;
            rsp_valid_reg <= 1'b0;
            layout_reg    <= L_ONE;
            ct_reg[0]     <= GHB_W;
            ch_reg[0]     <= GHB_W + LINK_W;
            for (int i = 1; i < 3; i++)
            begin
                ct_reg[i] <= '0;
                ch_reg[i] <= '0;
            end
            pend_st_reg  <= PEND_NONE;
            pend_off_reg <= '0;
            pend_len_reg <= '0;
            size_reg     <= INIT_W;
        end
        else
        begin
            state_reg     <= state_next;
            retry_reg     <= retry_next;
            rsp_valid_reg <= rsp_valid_next;
            layout_reg    <= layout_next;
            for (int i = 0; i < 3; i++)
            begin
                ct_reg[i] <= ct_next[i];
                ch_reg[i] <= ch_next[i];
            end
            pend_st_reg  <= pend_st_next;
            pend_off_reg <= pend_off_next;
            pend_len_reg <= pend_len_next;
            size_reg     <= size_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg  <= mode_next;
        len_reg   <= len_next;
        tail_reg  <= tail_next;
        lo_reg    <= lo_next;
        span_reg  <= span_next;
        off_reg   <= off_next;
        nst_reg   <= nst_next;
        need_reg  <= need_next;
        psize_reg <= psize_next;
        p_st_reg  <= p_st_next;
        for (int i = 0; i < 2; i++)
        begin
            p_ct_reg[i] <= p_ct_next[i];
            p_ch_reg[i] <= p_ch_next[i];
        end
        res_reg <= res_next;
        rsp_reg <= rsp_next;
    end

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule
